### rtl/cpf_pkg.sv
// ============================================================================
// cpf_pkg - shared definitions for the capture period FIFO
// Widths, reset values, action codes and the control structs between modules.
// ============================================================================
package cpf_pkg;

    localparam int unsigned CAPTURE_BITS   = 24;
    localparam int unsigned TIMEOUT_BITS   = 16;
    localparam int unsigned FIFO_DEPTH_DEF = 4;

    localparam logic [TIMEOUT_BITS-1:0] TIMEOUT_RESET = 16'd1024;

    // action codes of an input item
    localparam logic ACTION_POLL  = 1'b0;
    localparam logic ACTION_FETCH = 1'b1;

    typedef struct packed {
        logic                    action;
        logic                    overflow_seen;
        logic                    capture_ready;
        logic [CAPTURE_BITS-1:0] capture_value;
    } t_item;

    // tracker status toward the top level
    typedef struct packed {
        logic push;       // a difference is ready to enter the FIFO
        logic live_now;   // validity counter nonzero before this item
        logic live_next;  // validity counter nonzero after a poll item
    } t_track_ctl;

    // FIFO request from the top level
    typedef struct packed {
        logic step;  // pipeline advances this cycle
        logic push;
        logic pop;
    } t_fifo_req;

endpackage

### rtl/cpf_if.sv
// ============================================================================
// cpf_if - channel interfaces of the capture period FIFO
// Item input, result output and timeout register write channel.
// ============================================================================
interface cpf_item_if
    import cpf_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic                    action;
    logic                    overflow_seen;
    logic                    capture_ready;
    logic [CAPTURE_BITS-1:0] capture_value;

    modport source (
        output valid, action, overflow_seen, capture_ready, capture_value,
        input  ready
    );
    modport sink (
        input  valid, action, overflow_seen, capture_ready, capture_value,
        output ready
    );
endinterface

interface cpf_result_if
    import cpf_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic                    clock_valid;
    logic                    fetch_valid;
    logic [CAPTURE_BITS-1:0] fetch_value;

    modport source (
        output valid, clock_valid, fetch_valid, fetch_value,
        input  ready
    );
    modport sink (
        input  valid, clock_valid, fetch_valid, fetch_value,
        output ready
    );
endinterface

interface cpf_cfg_if
    import cpf_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic [TIMEOUT_BITS-1:0] data;

    modport source (
        output valid, data,
        input  ready
    );
    modport sink (
        input  valid, data,
        output ready
    );
endinterface

### rtl/cpf_tracker.sv
// ============================================================================
// cpf_tracker - clock validity counter and capture differencing
// Reload on overflow, count down otherwise, prime and subtract captures.
// ============================================================================
module cpf_tracker
    import cpf_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_step,
    input  logic [TIMEOUT_BITS-1:0] i_timeout,
    input  logic                    i_overflow_seen,
    input  logic                    i_capture_ready,
    input  logic [CAPTURE_BITS-1:0] i_capture_value,
    output t_track_ctl              o_ctl,
    output logic [CAPTURE_BITS-1:0] o_diff
);

    logic [TIMEOUT_BITS-1:0] r_count, n_count;
    logic [CAPTURE_BITS-1:0] r_prev;
    logic                    r_known;
    logic                    live_next;

    always_comb begin
        if (i_overflow_seen) begin
            n_count = i_timeout;
        end else if (r_count != '0) begin
            n_count = r_count - 1'b1;
        end else begin
            n_count = r_count;
        end
    end

    assign live_next       = (n_count != '0);
    assign o_ctl.live_now  = (r_count != '0);
    assign o_ctl.live_next = live_next;
    assign o_ctl.push      = live_next && i_capture_ready && r_known;
    // wraps modulo the capture width
    assign o_diff          = i_capture_value - r_prev;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_prev  <= '0;
            r_known <= 1'b0;
        end else if (i_step) begin
            r_count <= n_count;
            if (!live_next) begin
                r_known <= 1'b0;
            end else if (i_capture_ready) begin
                r_known <= 1'b1;
                r_prev  <= i_capture_value;
            end
        end
    end

`ifndef ASSERT_OFF
    a_invalid_clears_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && n_count == '0) |=> !r_known)
        else $error("previous capture still marked after clock went invalid");

    a_known_needs_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_known |-> (r_count != '0))
        else $error("previous capture marked while validity counter is zero");
`endif

endmodule

### rtl/cpf_period_fifo.sv
// ============================================================================
// cpf_period_fifo - ring buffer of period differences
// Holds FIFO_DEPTH-1 entries; drop on full, registered read on pop.
// ============================================================================
module cpf_period_fifo
    import cpf_pkg::*;
#(
    parameter int unsigned FIFO_DEPTH = FIFO_DEPTH_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_fifo_req               i_req,
    input  logic [CAPTURE_BITS-1:0] i_push_data,
    output logic                    o_pop_valid,
    output logic [CAPTURE_BITS-1:0] o_pop_data
);

    localparam int unsigned PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam logic [PTR_W-1:0] LAST = PTR_W'(FIFO_DEPTH - 1);

    logic [CAPTURE_BITS-1:0] r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0]        r_rd, r_wr;
    logic [PTR_W-1:0]        wr_next, rd_next;
    logic                    full, empty, do_push, do_pop;
    logic                    r_pop_valid;
    logic [CAPTURE_BITS-1:0] r_pop_data;

    assign wr_next = (r_wr == LAST) ? '0 : r_wr + 1'b1;
    assign rd_next = (r_rd == LAST) ? '0 : r_rd + 1'b1;
    assign full    = (wr_next == r_rd);
    assign empty   = (r_rd == r_wr);
    assign do_push = i_req.push && !full;
    assign do_pop  = i_req.pop && !empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_push_data;
        end
        if (i_req.step) begin
            r_pop_data <= do_pop ? r_mem[r_rd] : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd        <= '0;
            r_wr        <= '0;
            r_pop_valid <= 1'b0;
        end else begin
            if (do_push) begin
                r_wr <= wr_next;
            end
            if (do_pop) begin
                r_rd <= rd_next;
            end
            if (i_req.step) begin
                r_pop_valid <= do_pop;
            end
        end
    end

    assign o_pop_valid = r_pop_valid;
    assign o_pop_data  = r_pop_data;

`ifndef ASSERT_OFF
    a_one_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.push || i_req.pop) |-> i_req.step && !(i_req.push && i_req.pop))
        else $error("FIFO push and pop outside a single pipeline step");

    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rd <= LAST) && (r_wr <= LAST))
        else $error("FIFO pointer beyond last slot");

    a_pop_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.step && i_req.pop && !empty) |=> o_pop_valid)
        else $error("pop of a nonempty FIFO not reported");
`endif

endmodule

### rtl/capture_period_fifo_top.sv
// ============================================================================
// capture_period_fifo_top - reference clock period measurement
// Validity tracking of timer captures and a FIFO of capture differences.
// ============================================================================
// Each item is a timer poll (action 0) or a fetch (action 1) and yields
// exactly one result. A poll with overflow_seen reloads the validity counter
// from the timeout register, otherwise the counter steps down toward zero;
// while it is zero the previous capture is forgotten and captures are
// ignored. With the clock valid, a ready capture primes the previous value
// the first time and afterwards pushes (capture - previous) modulo 2^24 into
// a ring FIFO holding FIFO_DEPTH-1 entries; a push into a full FIFO is
// dropped. A fetch pops the oldest difference (fetch_valid=1) or returns
// zeros when the FIFO is empty. clock_valid reports the counter after the
// item. Throughput is one item per clock while the sink takes results;
// an item passes the input register and then the result register, where
// the FIFO read is registered. The input register doubles as a skid stage,
// so a new item is taken into it while a result waits for the sink, if it
// is empty. The timeout register resets to 1024 and is written through the
// cfg channel, which is always ready; write it only while the block is idle.
module capture_period_fifo_top
    import cpf_pkg::*;
#(
    parameter int unsigned FIFO_DEPTH = FIFO_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    cpf_item_if.sink      i_item,
    cpf_result_if.source  o_result,
    cpf_cfg_if.sink       i_cfg
);

    // timeout register
    logic [TIMEOUT_BITS-1:0] r_timeout;

    // input register stage
    logic  r_in_valid;
    t_item r_in;

    // result register stage
    logic r_out_valid;
    logic r_out_clock_valid;

    logic       advance;
    logic       is_poll;
    t_track_ctl track;
    t_fifo_req  fifo_req;
    logic [CAPTURE_BITS-1:0] diff;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TIMEOUT_RESET;
        end else if (i_cfg.valid) begin
            r_timeout <= i_cfg.data;
        end
    end

    // advance the held item when the result slot is free or being emptied
    assign advance      = r_in_valid && (!r_out_valid || o_result.ready);
    assign i_item.ready = !r_in_valid || advance;
    assign is_poll      = (r_in.action == ACTION_POLL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_item.valid && i_item.ready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    // payload register, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_in.action        <= i_item.action;
            r_in.overflow_seen <= i_item.overflow_seen;
            r_in.capture_ready <= i_item.capture_ready;
            r_in.capture_value <= i_item.capture_value;
        end
    end

    cpf_tracker u_tracker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_step          (advance && is_poll),
        .i_timeout       (r_timeout),
        .i_overflow_seen (r_in.overflow_seen),
        .i_capture_ready (r_in.capture_ready),
        .i_capture_value (r_in.capture_value),
        .o_ctl           (track),
        .o_diff          (diff)
    );

    // push only on an advancing poll; pop only on an advancing fetch
    assign fifo_req.step = advance;
    assign fifo_req.push = advance && is_poll && track.push;
    assign fifo_req.pop  = advance && !is_poll;

    cpf_period_fifo #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (fifo_req),
        .i_push_data (diff),
        .o_pop_valid (o_result.fetch_valid),
        .o_pop_data  (o_result.fetch_value)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_clock_valid <= is_poll ? track.live_next : track.live_now;
        end
    end

    assign o_result.valid       = r_out_valid;
    assign o_result.clock_valid = r_out_clock_valid;

`ifndef ASSERT_OFF
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_result.ready) |=> ($stable(o_result.clock_valid)
            && $stable(o_result.fetch_valid) && $stable(o_result.fetch_value)))
        else $error("held result changed while stalled");
`endif

endmodule

### test/capture_period_fifo_top_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// capture_period_fifo_top_tb - self-checking bench for the capture period FIFO
// Drives poll and fetch items through the item channel, predicts every result
// from a local model of the validity counter, previous capture and ring FIFO,
// and checks each result in order. A directed table runs first, then random
// phases over several timeout settings and idle patterns on both channels.
// ============================================================================
module capture_period_fifo_top_tb;
    import cpf_pkg::*;

    localparam int unsigned CYCLE_LIMIT    = 100000;
    localparam int unsigned SETTLE_CYCLES  = 6;
    localparam int unsigned RANDOM_PHASES  = 6;
    localparam int unsigned PHASE_ITEMS    = 108;

    // One result item as the bench sees it.
    typedef struct packed {
        logic                    clock_valid;
        logic                    fetch_valid;
        logic [CAPTURE_BITS-1:0] fetch_value;
    } t_outcome;

    // Directed table: a row is either an item or a timeout register write.
    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_kind;

    typedef struct {
        t_row_kind               kind;
        logic                    action;
        logic                    overflow_seen;
        logic                    capture_ready;
        logic [CAPTURE_BITS-1:0] capture_value;
        logic [TIMEOUT_BITS-1:0] timeout_data;
        logic                    typed;        // expected result written in the row
        logic                    exp_clock;
        logic                    exp_fetch;
        logic [CAPTURE_BITS-1:0] exp_value;
    } t_stim_row;

    logic clk;
    logic rst_n;

    cpf_item_if   item_ch();
    cpf_result_if res_ch();
    cpf_cfg_if    cfg_ch();

    capture_period_fifo_top DUT (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_item   (item_ch),
        .o_result (res_ch),
        .i_cfg    (cfg_ch)
    );

    // Period 4 ns.
    initial clk = 1'b0;
    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Local copy of the block state: timeout register, validity counter,
    // previous capture mark and the ring of period differences.
    // ------------------------------------------------------------------------
    logic [TIMEOUT_BITS-1:0] timeout_reg;
    logic [TIMEOUT_BITS-1:0] live_count;
    logic [CAPTURE_BITS-1:0] last_capture;
    logic                    last_known;
    logic [CAPTURE_BITS-1:0] period_ring [FIFO_DEPTH_DEF];
    int unsigned             rd_ptr;
    int unsigned             wr_ptr;

    // Results still owed by the block, oldest first.
    t_outcome    pending_outcomes[$];
    int unsigned fail_count;
    int unsigned cycle_count;

    // Idle percentages, changed per phase of the run.
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;

    // Running timer value, so random captures mostly form plausible periods.
    logic [31:0] timer_mark;

    // Advance the local state by one item and return the result it causes.
    function automatic t_outcome predict_outcome(input t_item it);
        t_outcome                o;
        logic [CAPTURE_BITS-1:0] diff;
        int unsigned             nxt;
        o = '0;
        if (it.action == ACTION_POLL) begin
            // overflow reloads, otherwise count down and stick at zero
            if (it.overflow_seen) begin
                live_count = timeout_reg;
            end else if (live_count != '0) begin
                live_count = live_count - 1'b1;
            end
            if (live_count == '0) begin
                // clock absent: forget the previous capture, ignore this one
                last_known = 1'b0;
            end else if (it.capture_ready) begin
                if (last_known) begin
                    diff = it.capture_value - last_capture;
                    nxt  = (wr_ptr + 1) % FIFO_DEPTH_DEF;
                    // ring keeps one slot free; drop the difference when full
                    if (nxt != rd_ptr) begin
                        period_ring[wr_ptr] = diff;
                        wr_ptr = nxt;
                    end
                end
                last_known   = 1'b1;
                last_capture = it.capture_value;
            end
        end else if (rd_ptr != wr_ptr) begin
            o.fetch_valid = 1'b1;
            o.fetch_value = period_ring[rd_ptr];
            rd_ptr = (rd_ptr + 1) % FIFO_DEPTH_DEF;
        end
        o.clock_valid = (live_count != '0);
        return o;
    endfunction

    // Mostly polls with a running timer; fetches carry noise in the
    // fields they ignore, and now and then the timer jumps anywhere.
    function automatic t_item random_item(input int unsigned ovf_pct);
        t_item it;
        it = '0;
        if ($urandom_range(0, 99) < 35) begin
            it.action        = ACTION_FETCH;
            it.overflow_seen = 1'($urandom_range(0, 1));
            it.capture_ready = 1'($urandom_range(0, 1));
            it.capture_value = CAPTURE_BITS'($urandom);
        end else begin
            it.action        = ACTION_POLL;
            it.overflow_seen = ($urandom_range(0, 99) < ovf_pct);
            it.capture_ready = ($urandom_range(0, 99) < 60);
            if ($urandom_range(0, 9) == 0) begin
                timer_mark = $urandom;
            end else begin
                timer_mark = timer_mark + $urandom_range(1, 5000);
            end
            it.capture_value = timer_mark[CAPTURE_BITS-1:0];
        end
        return it;
    endfunction

    // Present one item from a falling edge and hold it until accepted; then
    // queue its expected result. Returns at the falling edge after acceptance.
    task automatic send_item(input t_item it, input logic typed, input t_outcome typed_exp);
        t_outcome predicted;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            item_ch.valid <= 1'b0;
            @(negedge clk);
        end
        item_ch.valid         <= 1'b1;
        item_ch.action        <= it.action;
        item_ch.overflow_seen <= it.overflow_seen;
        item_ch.capture_ready <= it.capture_ready;
        item_ch.capture_value <= it.capture_value;
        @(posedge clk);
        while (!item_ch.ready) @(posedge clk);
        predicted = predict_outcome(it);
        pending_outcomes.push_back(typed ? typed_exp : predicted);
        @(negedge clk);
    endtask

    // Drop valid, drain every owed result, then give the pipeline time to
    // settle before the register may change.
    task automatic wait_drained();
        item_ch.valid <= 1'b0;
        while (pending_outcomes.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_timeout(input logic [TIMEOUT_BITS-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        timeout_reg = value;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Result side: randomize ready at the falling edge, check at the rising.
    // ------------------------------------------------------------------------
    always @(negedge clk) begin
        res_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge clk) begin : result_check
        t_outcome want;
        if (rst_n && res_ch.valid && res_ch.ready) begin
            if (pending_outcomes.size() == 0) begin
                fail_count++;
                $display("%0t: unexpected result clock_valid=%0b fetch_valid=%0b value=%06h",
                         $time, res_ch.clock_valid, res_ch.fetch_valid,
                         res_ch.fetch_value);
            end else begin
                want = pending_outcomes.pop_front();
                if (res_ch.clock_valid !== want.clock_valid ||
                    res_ch.fetch_valid !== want.fetch_valid ||
                    res_ch.fetch_value !== want.fetch_value) begin
                    fail_count++;
                    $display("%0t: result mismatch expected %0b/%0b/%06h actual %0b/%0b/%06h",
                             $time, want.clock_valid, want.fetch_valid,
                             want.fetch_value, res_ch.clock_valid,
                             res_ch.fetch_valid, res_ch.fetch_value);
                end
            end
        end
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("capture_period_fifo_top verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        t_stim_row               dir_rows[$];
        t_stim_row               row;
        t_item                   it;
        t_outcome                exp_o;
        logic [TIMEOUT_BITS-1:0] phase_timeout;
        int unsigned             phase_ovf;

        // Known values on every input from time zero.
        rst_n                 = 1'b0;
        item_ch.valid         = 1'b0;
        item_ch.action        = ACTION_POLL;
        item_ch.overflow_seen = 1'b0;
        item_ch.capture_ready = 1'b0;
        item_ch.capture_value = '0;
        res_ch.ready          = 1'b0;
        cfg_ch.valid          = 1'b0;
        cfg_ch.data           = '0;

        timeout_reg  = TIMEOUT_RESET;
        live_count   = '0;
        last_capture = '0;
        last_known   = 1'b0;
        rd_ptr       = 0;
        wr_ptr       = 0;
        fail_count   = 0;
        cycle_count  = 0;
        timer_mark   = $urandom;

        // sender idles lightly, receiver heavily
        send_idle_pct = 17;
        recv_idle_pct = 67;

        // Directed table. Rows with typed set carry the obvious answer;
        // the rest are checked against the predictor.
        // After reset the clock is invalid and the FIFO empty.
        dir_rows.push_back('{ROW_ITEM, ACTION_POLL,  1'b0, 1'b1, 24'h123456, 16'd0,
                             1'b1, 1'b0, 1'b0, 24'h000000});
        dir_rows.push_back('{ROW_ITEM, ACTION_FETCH, 1'b0, 1'b0, 24'h000000, 16'd0,
                             1'b1, 1'b0, 1'b0, 24'h000000});
        // Overflow validates with the reset timeout; first capture only primes.
        dir_rows.push_back('{ROW_ITEM, ACTION_POLL,  1'b1, 1'b1, 24'h000000, 16'd0,
                             1'b1, 1'b1, 1'b0, 24'h000000});
        // Capture extremes and wrap-around: differences FFFFFF, 1, 10.
        dir_rows.push_back('{ROW_ITEM, ACTION_POLL,  1'b0, 1'b1, 24'hFFFFFF, 16'd0,
                             1'b1, 1'b1, 1'b0, 24'h000000});
        dir_rows.push_back('{ROW_ITEM, ACTION_POLL,  1'b0, 1'b1, 24'h000000, 16'd0,
                             1'b1, 1'b1, 1'b0, 24'h000000});
        dir_rows.push_back('{ROW_ITEM, ACTION_POLL,  1'b0, 1'b1, 24'h000010, 16'd0,
                             1'b1, 1'b1, 1'b0, 24'h000000});
        // FIFO full: difference dropped, previous capture still moves.
        dir_rows.push_back('{ROW_ITEM, ACTION_POLL,  1'b0, 1'b1, 24'h800000, 16'd0,
                             1'b1, 1'b1, 1'b0, 24'h000000});
        dir_rows.push_back('{ROW_ITEM, ACTION_FETCH, 1'b0, 1'b0, 24'h000000, 16'd0,
                             1'b1, 1'b1, 1'b1, 24'hFFFFFF});
        dir_rows.push_back('{ROW_ITEM, ACTION_FETCH, 1'b0, 1'b0, 24'h000000, 16'd0,
                             1'b1, 1'b1, 1'b1, 24'h000001});
        dir_rows.push_back('{ROW_ITEM, ACTION_FETCH, 1'b0, 1'b0, 24'h000000, 16'd0,
                             1'b1, 1'b1, 1'b1, 24'h000010});
        dir_rows.push_back('{ROW_ITEM, ACTION_FETCH, 1'b0, 1'b0, 24'h000000, 16'd0,
                             1'b1, 1'b1, 1'b0, 24'h000000});
        // Overflow without a capture; fetch with all side fields set.
        dir_rows.push_back('{ROW_ITEM, ACTION_POLL,  1'b1, 1'b0, 24'hABCDEF, 16'd0,
                             1'b1, 1'b1, 1'b0, 24'h000000});
        dir_rows.push_back('{ROW_ITEM, ACTION_FETCH, 1'b1, 1'b1, 24'hFFFFFF, 16'd0,
                             1'b1, 1'b1, 1'b0, 24'h000000});
        // Capture after the dropped push measures from the dropped one.
        dir_rows.push_back('{ROW_ITEM, ACTION_POLL,  1'b0, 1'b1, 24'h800005, 16'd0,
                             1'b0, 1'b0, 1'b0, 24'h000000});
        dir_rows.push_back('{ROW_ITEM, ACTION_FETCH, 1'b0, 1'b0, 24'h000000, 16'd0,
                             1'b0, 1'b0, 1'b0, 24'h000000});
        // Shortest timeout: a poll without overflow expires the clock.
        dir_rows.push_back('{ROW_CFG,  ACTION_POLL,  1'b0, 1'b0, 24'h000000, 16'd1,
                             1'b0, 1'b0, 1'b0, 24'h000000});
        dir_rows.push_back('{ROW_ITEM, ACTION_POLL,  1'b1, 1'b0, 24'h000100, 16'd0,
                             1'b1, 1'b1, 1'b0, 24'h000000});
        dir_rows.push_back('{ROW_ITEM, ACTION_POLL,  1'b0, 1'b1, 24'h000200, 16'd0,
                             1'b1, 1'b0, 1'b0, 24'h000000});
        dir_rows.push_back('{ROW_ITEM, ACTION_POLL,  1'b1, 1'b1, 24'h000300, 16'd0,
                             1'b1, 1'b1, 1'b0, 24'h000000});
        dir_rows.push_back('{ROW_ITEM, ACTION_POLL,  1'b1, 1'b1, 24'h000400, 16'd0,
                             1'b1, 1'b1, 1'b0, 24'h000000});
        dir_rows.push_back('{ROW_ITEM, ACTION_FETCH, 1'b0, 1'b0, 24'h000000, 16'd0,
                             1'b1, 1'b1, 1'b1, 24'h000100});
        // Timeout of zero: overflow reloads zero, clock stays invalid.
        dir_rows.push_back('{ROW_CFG,  ACTION_POLL,  1'b0, 1'b0, 24'h000000, 16'd0,
                             1'b0, 1'b0, 1'b0, 24'h000000});
        dir_rows.push_back('{ROW_ITEM, ACTION_POLL,  1'b1, 1'b1, 24'h000005, 16'd0,
                             1'b1, 1'b0, 1'b0, 24'h000000});
        dir_rows.push_back('{ROW_ITEM, ACTION_FETCH, 1'b0, 1'b0, 24'h000000, 16'd0,
                             1'b1, 1'b0, 1'b0, 24'h000000});
        // Largest timeout, wrap from all ones to zero.
        dir_rows.push_back('{ROW_CFG,  ACTION_POLL,  1'b0, 1'b0, 24'h000000, 16'hFFFF,
                             1'b0, 1'b0, 1'b0, 24'h000000});
        dir_rows.push_back('{ROW_ITEM, ACTION_POLL,  1'b1, 1'b1, 24'hFFFFFF, 16'd0,
                             1'b0, 1'b0, 1'b0, 24'h000000});
        dir_rows.push_back('{ROW_ITEM, ACTION_POLL,  1'b0, 1'b1, 24'h000000, 16'd0,
                             1'b0, 1'b0, 1'b0, 24'h000000});
        dir_rows.push_back('{ROW_ITEM, ACTION_FETCH, 1'b0, 1'b0, 24'h000000, 16'd0,
                             1'b1, 1'b1, 1'b1, 24'h000001});

        // Hold reset, release on a falling edge.
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir_rows[r]) begin
            row = dir_rows[r];
            if (row.kind == ROW_CFG) begin
                wait_drained();
                write_timeout(row.timeout_data);
            end else begin
                it.action        = row.action;
                it.overflow_seen = row.overflow_seen;
                it.capture_ready = row.capture_ready;
                it.capture_value = row.capture_value;
                exp_o.clock_valid = row.exp_clock;
                exp_o.fetch_valid = row.exp_fetch;
                exp_o.fetch_value = row.exp_value;
                send_item(it, row.typed, exp_o);
            end
        end

        // Random phases: each one drains, sets a new timeout and overflow
        // rate, then streams items. Short timeouts get frequent overflows so
        // the clock keeps coming back; long ones rarely see overflow.
        for (int unsigned ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph)
                0: begin phase_timeout = 16'hFFFF;                  phase_ovf = 10; end
                1: begin phase_timeout = 16'd1;                     phase_ovf = 70; end
                2: begin phase_timeout = 16'd3;                     phase_ovf = 40; end
                3: begin
                    phase_timeout = TIMEOUT_BITS'($urandom_range(2, 50));
                    phase_ovf     = 25;
                end
                4: begin
                    phase_timeout = TIMEOUT_BITS'($urandom_range(1, 65535));
                    phase_ovf     = 15;
                end
                default: begin phase_timeout = TIMEOUT_RESET;       phase_ovf = 5;  end
            endcase
            // swap the idle roles after two phases, then run without idling
            if (ph == 2) begin
                send_idle_pct = 67;
                recv_idle_pct = 17;
            end else if (ph == 4) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            wait_drained();
            write_timeout(phase_timeout);
            for (int unsigned n = 0; n < PHASE_ITEMS; n++) begin
                send_item(random_item(phase_ovf), 1'b0, '0);
            end
        end

        // Drain and allow for stragglers before the verdict.
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0) begin
            $display("capture_period_fifo_top verification clean");
        end else begin
            $display("capture_period_fifo_top verification failed");
        end
        $finish;
    end

endmodule

### files.f
rtl/cpf_pkg.sv
rtl/cpf_if.sv
rtl/cpf_tracker.sv
rtl/cpf_period_fifo.sv
rtl/capture_period_fifo_top.sv
test/capture_period_fifo_top_tb.sv
